// ===== src/utxq_pkg.sv =====
package utxq_pkg;

    localparam int BUF_LEN_DEF = 32;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_NUL = 8'h00;

    typedef enum logic [2:0] {
        OP_QUEUE      = 3'd0,
        OP_TX_EMPTY   = 3'd1,
        OP_RX_BYTE    = 3'd2,
        OP_LINE_START = 3'd3,
        OP_LINE_READ  = 3'd4
    } t_op;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] push_byte;
    } t_txq_req;

    typedef struct packed {
        logic       pushed;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       full_after;
    } t_txq_stat;

    typedef struct packed {
        logic       rx;
        logic       start;
        logic [7:0] rx_byte;
    } t_line_req;

    typedef struct packed {
        logic active;
        logic done;
        logic active_after;
    } t_line_stat;

endpackage

// ===== src/utxq_tx_queue.sv =====
module utxq_tx_queue #(
    parameter int BUF_LEN = utxq_pkg::BUF_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  utxq_pkg::t_txq_req  i_req,
    output utxq_pkg::t_txq_stat o_stat
);
    import utxq_pkg::*;

    localparam int PW = (BUF_LEN > 1) ? $clog2(BUF_LEN) : 1;

    logic [7:0]    r_mem [BUF_LEN];
    logic [7:0]    r_head;
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic          r_full;
    logic          r_sending;

    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic          n_full;
    logic          n_sending;
    logic [PW-1:0] wr_inc;
    logic [PW-1:0] rd_inc;
    logic          push_ok;
    logic          pop_ok;

    assign wr_inc  = (r_wr == PW'(BUF_LEN - 1)) ? '0 : r_wr + 1'b1;
    assign rd_inc  = (r_rd == PW'(BUF_LEN - 1)) ? '0 : r_rd + 1'b1;
    assign push_ok = i_req.push && !r_full;
    assign pop_ok  = i_req.pop && r_sending;

    always_comb begin
        n_wr      = r_wr;
        n_rd      = r_rd;
        n_full    = r_full;
        n_sending = r_sending;
        if (push_ok) begin
            n_wr      = wr_inc;
            n_full    = (wr_inc == r_rd);
            n_sending = 1'b1;
        end else if (pop_ok) begin
            n_rd      = rd_inc;
            n_full    = 1'b0;
            n_sending = (rd_inc != r_wr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr      <= '0;
            r_rd      <= '0;
            r_full    <= 1'b0;
            r_sending <= 1'b0;
        end else begin
            r_wr      <= n_wr;
            r_rd      <= n_rd;
            r_full    <= n_full;
            r_sending <= n_sending;
        end
    end

    // store write, and the oldest word prefetched for the next pop
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_req.push_byte;
        end
        if (push_ok && (r_wr == n_rd)) begin
            r_head <= i_req.push_byte;
        end else begin
            r_head <= r_mem[n_rd];
        end
    end

    assign o_stat.pushed     = push_ok;
    assign o_stat.tx_valid   = pop_ok;
    assign o_stat.tx_byte    = pop_ok ? r_head : 8'h00;
    assign o_stat.full_after = n_full;

    a_full_ptrs : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_wr == r_rd))
        else $error("full flag set with unequal pointers");

    a_idle_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sending |-> ((r_wr == r_rd) && !r_full))
        else $error("sending off while store holds words");

    a_push_sends : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_ok |=> r_sending)
        else $error("push did not start sending");

endmodule

// ===== src/utxq_line_reader.sv =====
module utxq_line_reader #(
    parameter int BUF_LEN = utxq_pkg::BUF_LEN_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  utxq_pkg::t_line_req                    i_req,
    input  logic                                   i_rd_en,
    input  logic [4:0]                             i_rd_index,
    output utxq_pkg::t_line_stat                   o_stat,
    output logic [((BUF_LEN > 1) ? $clog2(BUF_LEN) : 1)-1:0] o_line_count,
    output logic [7:0]                             o_entry_byte
);
    import utxq_pkg::*;

    localparam int LW = (BUF_LEN > 1) ? $clog2(BUF_LEN) : 1;

    logic [7:0]         r_mem [BUF_LEN];
    logic [BUF_LEN-1:0] r_vld;
    logic [LW-1:0]      r_count;
    logic               r_active;
    logic [7:0]         r_entry;

    logic [LW-1:0] n_count;
    logic          n_active;
    logic          rx_live;
    logic          store_byte;
    logic          terminate;
    logic [7:0]    wr_data;
    logic [31:0]   idx_wide;
    logic [LW-1:0] rd_addr;
    logic          idx_ok;

    assign rx_live    = i_req.rx && r_active;
    assign store_byte = rx_live && (i_req.rx_byte != CH_CR) && (i_req.rx_byte != CH_NUL)
                        && (r_count < LW'(BUF_LEN - 1));
    assign terminate  = rx_live && !store_byte;
    assign wr_data    = store_byte ? i_req.rx_byte : CH_NUL;

    always_comb begin
        n_count  = r_count;
        n_active = r_active;
        if (i_req.start) begin
            n_count  = '0;
            n_active = 1'b1;
        end else if (store_byte) begin
            n_count = r_count + 1'b1;
        end else if (terminate) begin
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_active <= 1'b0;
            r_vld    <= '0;
        end else begin
            r_count  <= n_count;
            r_active <= n_active;
            if (rx_live) begin
                r_vld[r_count] <= 1'b1;
            end
        end
    end

    assign idx_wide = 32'(i_rd_index);
    assign rd_addr  = idx_wide[LW-1:0];
    assign idx_ok   = (idx_wide < 32'(BUF_LEN));

    // entry read on input acceptance, with the concurrent line write forwarded
    always_ff @(posedge i_clk) begin
        if (rx_live) begin
            r_mem[r_count] <= wr_data;
        end
        if (i_rd_en) begin
            if (!idx_ok) begin
                r_entry <= 8'h00;
            end else if (rx_live && (r_count == rd_addr)) begin
                r_entry <= wr_data;
            end else if (r_vld[rd_addr]) begin
                r_entry <= r_mem[rd_addr];
            end else begin
                r_entry <= 8'h00;
            end
        end
    end

    assign o_stat.active       = r_active;
    assign o_stat.done         = terminate;
    assign o_stat.active_after = n_active;
    assign o_line_count        = n_count;
    assign o_entry_byte        = r_entry;

endmodule

// ===== src/uart_tx_queue_with_echo_line_reader_core.sv =====
// an accepted word is held in the input register, and its result word then in the result register
// throughput: one word per cycle while the result side keeps tready high
// the input register and result register stall together on result backpressure
// reset: synchronous active-low, pointers, flags, line count and entry valid bits clear
// line store entries never written since reset read as zero
module uart_tx_queue_with_echo_line_reader_core #(
    parameter int BUF_LEN = utxq_pkg::BUF_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // data_byte[7:0], line_index[12:8], zero fill
    input  logic [15:0] i_s_axis_tdata,
    // operation[2:0]
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tx_valid[0], tx_byte[8:1], queued[9], queue_full[10], echo_dropped[11],
    // line_done[12], reading[13], line_length[18:14], entry_byte[26:19], zero fill
    output logic [31:0] o_m_axis_tdata
);
    import utxq_pkg::*;

    localparam int LW = (BUF_LEN > 1) ? $clog2(BUF_LEN) : 1;

    logic       r_in_valid;
    logic [2:0] r_op;
    logic [7:0] r_byte;

    logic       r_out_valid;
    logic       r_tx_valid;
    logic [7:0] r_tx_byte;
    logic       r_queued;
    logic       r_queue_full;
    logic       r_echo_dropped;
    logic       r_line_done;
    logic       r_reading;
    logic [4:0] r_line_length;
    logic [7:0] r_entry_byte;

    logic       fire;
    logic       accept;
    t_txq_req   txq_req;
    t_txq_stat  txq_stat;
    t_line_req  line_req;
    t_line_stat line_stat;
    logic [LW-1:0] line_count;
    logic [7:0]    entry_byte;
    logic [31:0]   count_wide;
    logic          is_rx;

    assign fire            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || fire;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_s_axis_tuser;
            r_byte <= i_s_axis_tdata[7:0];
        end
    end

    assign is_rx = (r_op == OP_RX_BYTE);

    // the echo only goes to the queue while a line read is running
    assign txq_req.push      = fire && ((r_op == OP_QUEUE) || (is_rx && line_stat.active));
    assign txq_req.pop       = fire && (r_op == OP_TX_EMPTY);
    assign txq_req.push_byte = r_byte;

    assign line_req.rx      = fire && is_rx;
    assign line_req.start   = fire && (r_op == OP_LINE_START);
    assign line_req.rx_byte = r_byte;

    utxq_tx_queue #(
        .BUF_LEN (BUF_LEN)
    ) u_tx_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (txq_req),
        .o_stat  (txq_stat)
    );

    utxq_line_reader #(
        .BUF_LEN (BUF_LEN)
    ) u_line_reader (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (line_req),
        .i_rd_en      (accept),
        .i_rd_index   (i_s_axis_tdata[12:8]),
        .o_stat       (line_stat),
        .o_line_count (line_count),
        .o_entry_byte (entry_byte)
    );

    assign count_wide = 32'(line_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_tx_valid     <= txq_stat.tx_valid;
            r_tx_byte      <= txq_stat.tx_byte;
            r_queued       <= (r_op == OP_QUEUE) && txq_stat.pushed;
            r_queue_full   <= txq_stat.full_after;
            r_echo_dropped <= is_rx && line_stat.active && !txq_stat.pushed;
            r_line_done    <= line_stat.done;
            r_reading      <= line_stat.active_after;
            r_line_length  <= count_wide[4:0];
            r_entry_byte   <= (r_op == OP_LINE_READ) ? entry_byte : 8'h00;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_entry_byte, r_line_length, r_reading, r_line_done,
                              r_echo_dropped, r_queue_full, r_queued, r_tx_byte, r_tx_valid};

    a_one_queue_act : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_tx_valid && r_queued))
        else $error("pop and push reported in one result");

    a_done_stops : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_line_done) |-> !r_reading)
        else $error("line ended but read still active");

    a_drop_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_echo_dropped) |-> r_queue_full)
        else $error("echo dropped while queue had room");

endmodule
